[rtl/dmad_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dmad_pkg;

  localparam int SAMPLE_W       = 12;
  localparam int SCALE_W        = 16;
  localparam int THRESH_W       = 12;
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int WINDOW_DEFAULT = 8;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd2;
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 16'd36218;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANGE_THRESHOLD = 2'd0,
    CFG_SCALE_FACTOR     = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_DIV_LOAD,
    S_DIV,
    S_MUL,
    S_DECIDE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic push;
    logic div_load;
    logic div_step;
    logic mul;
    logic decide;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic phase;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[rtl/dmad_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface dmad_in_if;
  import dmad_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface dmad_out_if;
  import dmad_pkg::*;

  logic                valid;
  logic                ready;
  logic                processed;
  logic [SAMPLE_W-1:0] average;
  logic [SAMPLE_W-1:0] scaled_value;
  logic [SAMPLE_W-1:0] distance;
  logic                distance_updated;

  modport source (output valid, output processed, output average, output scaled_value,
                  output distance, output distance_updated, input ready);
  modport sink   (input valid, input processed, input average, input scaled_value,
                  input distance, input distance_updated, output ready);
endinterface

`default_nettype wire

[rtl/decimated_moving_average_deadband.sv]
`timescale 1ns / 1ps
`default_nettype none

// Decimated moving average with deadband. Every input transaction yields one
// result transaction. Only every second transaction (the second after reset,
// then alternating) is handled: its sample enters a sliding window of the
// newest WINDOW samples, the truncated average over the samples held so far
// is scaled by the Q0.16 scale_factor, and the held distance moves to the
// scaled value only when it differs from it by at least change_threshold.
// The other transactions return processed = 0 with the held distance. One
// item is worked at a time: a skipped sample passes through S_EMIT only, a
// handled one through S_PUSH, S_DIV_LOAD, S_DIV, S_MUL, S_DECIDE and S_EMIT;
// in S_DIV the bit-serial divider divides the running sum by the fill count
// one quotient bit per cycle. A finished result waits in the output register
// while the next sample is accepted. Configuration writes (index 0:
// change_threshold, index 1: scale_factor) take effect at once and belong
// only in idle periods; the window memory needs no clearing after reset.
module decimated_moving_average_deadband #(
  parameter int WINDOW = dmad_pkg::WINDOW_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  dmad_in_if.sink                             samples,
  dmad_out_if.source                          results,
  input  wire logic                           cfg_we,
  input  wire logic [dmad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dmad_pkg::CFG_W-1:0]     cfg_data
);
  import dmad_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dmad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dmad_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .adc_sample (samples.adc_sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .results    (results)
  );

endmodule

`default_nettype wire

[rtl/dmad_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module dmad_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/dmad_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module dmad_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire dmad_pkg::sts_t sts,
  output dmad_pkg::cmd_t     cmd
);
  import dmad_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = sts.phase ? S_PUSH : S_EMIT;
        end
      end
      S_PUSH:     state_next = S_DIV_LOAD;
      S_DIV_LOAD: state_next = S_DIV;
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_MUL;
        end
      end
      S_MUL:      state_next = S_DECIDE;
      S_DECIDE:   state_next = S_EMIT;
      S_EMIT: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_PUSH:     cmd.push     = 1'b1;
      S_DIV_LOAD: cmd.div_load = 1'b1;
      S_DIV:      cmd.div_step = !sts.div_done;
      S_MUL:      cmd.mul      = 1'b1;
      S_DECIDE:   cmd.decide   = 1'b1;
      S_EMIT:     cmd.emit     = sts.out_free;
      default:    cmd          = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/dmad_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module dmad_dp #(
  parameter int WINDOW = dmad_pkg::WINDOW_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [dmad_pkg::SAMPLE_W-1:0] adc_sample,
  input  wire logic                         cfg_we,
  input  wire logic [dmad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dmad_pkg::CFG_W-1:0]   cfg_data,
  input  wire dmad_pkg::cmd_t               cmd,
  output dmad_pkg::sts_t                    sts,
  dmad_out_if.source                        results
);
  import dmad_pkg::*;

  localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam int PROD_W = SAMPLE_W + SCALE_W;

  logic [THRESH_W-1:0] change_threshold;
  logic [SCALE_W-1:0]  scale_factor;

  logic                phase;
  logic                proc;
  logic [SAMPLE_W-1:0] sample;
  logic [PTR_W-1:0]    wptr;
  logic [CNT_W-1:0]    fill_count;
  logic [SUM_W-1:0]    running_sum;
  logic [SAMPLE_W-1:0] oldest;
  logic [SUM_W-1:0]    quo;
  logic [CNT_W-1:0]    rem;
  logic [STEP_W-1:0]   steps;
  logic [SAMPLE_W-1:0] scaled;
  logic [SAMPLE_W-1:0] held_distance;
  logic                updated;
  logic                out_valid;

  logic                full;
  logic [SUM_W-1:0]    sum_next;
  logic [CNT_W:0]      rem_shift;
  logic                rem_ge;
  logic [PROD_W-1:0]   product;
  logic [SAMPLE_W-1:0] diff;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      change_threshold <= THRESH_RESET;
      scale_factor     <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CHANGE_THRESHOLD: change_threshold <= cfg_data[THRESH_W-1:0];
        CFG_SCALE_FACTOR:     scale_factor     <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // circular window, oldest entry sits at the write pointer once full
  dmad_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (wptr),
    .wdata (sample),
    .raddr (wptr),
    .rdata (oldest)
  );

  assign full     = (fill_count == CNT_W'(WINDOW));
  assign sum_next = running_sum - (full ? SUM_W'(oldest) : '0) + SUM_W'(sample);

  assign rem_shift = {rem, quo[SUM_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, fill_count});

  assign product = PROD_W'(quo[SAMPLE_W-1:0]) * PROD_W'(scale_factor);
  assign diff    = (scaled > held_distance) ? (scaled - held_distance)
                                            : (held_distance - scaled);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= 1'b0;
      wptr          <= '0;
      fill_count    <= '0;
      running_sum   <= '0;
      held_distance <= '0;
      steps         <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.capture) begin
        phase <= ~phase;
      end
      if (cmd.push) begin
        running_sum <= sum_next;
        wptr        <= (wptr == PTR_W'(WINDOW - 1)) ? '0 : wptr + 1'b1;
        if (!full) begin
          fill_count <= fill_count + 1'b1;
        end
      end
      if (cmd.div_load) begin
        steps <= STEP_W'(SUM_W);
      end else if (cmd.div_step) begin
        steps <= steps - 1'b1;
      end
      if (cmd.decide && (diff >= change_threshold)) begin
        held_distance <= scaled;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample  <= adc_sample;
      proc    <= phase;
      updated <= 1'b0;
    end
    if (cmd.div_load) begin
      quo <= running_sum;
      rem <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[SUM_W-2:0], rem_ge};
      rem <= rem_ge ? CNT_W'(rem_shift - {1'b0, fill_count}) : rem_shift[CNT_W-1:0];
    end
    if (cmd.mul) begin
      scaled <= product[PROD_W-1:SCALE_W];
    end
    if (cmd.decide) begin
      updated <= (diff >= change_threshold);
    end
    if (cmd.emit) begin
      results.processed        <= proc;
      results.average          <= proc ? quo[SAMPLE_W-1:0] : '0;
      results.scaled_value     <= proc ? scaled : '0;
      results.distance         <= held_distance;
      results.distance_updated <= updated;
    end
  end

  assign results.valid = out_valid;

  assign sts.phase    = phase;
  assign sts.div_done = (steps == '0);
  assign sts.out_free = !out_valid || results.ready;

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(WINDOW))
    else $error("window fill count beyond window length");

  assert property (@(posedge clk) disable iff (rst)
    (fill_count != CNT_W'(WINDOW)) |-> (CNT_W'(wptr) == fill_count))
    else $error("write pointer out of step with fill count");

  assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < fill_count))
    else $error("divider remainder not below divisor");

  assert property (@(posedge clk) disable iff (rst)
    cmd.mul |-> ((quo >> SAMPLE_W) == '0))
    else $error("average does not fit sample width");
`endif

endmodule

`default_nettype wire
